// ----- rtl/priority_ready_queue_scheduler_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the priority ready queue scheduler
// Shared property forms that check the scheduler's internal sequencing.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_TOP_MACROS_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PRQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/prq_pkg.sv -----
// ----------------------------------------------------------------------------
// prq_pkg
// Types and codes shared by the priority ready queue scheduler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package prq_pkg;

    localparam logic [1:0] CMD_RESCHEDULE = 2'd0;
    localparam logic [1:0] CMD_UNSCHEDULE = 2'd1;
    localparam logic [1:0] CMD_TAKE_NEXT  = 2'd2;
    localparam logic [1:0] CMD_QUERY      = 2'd3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_VALUE_ERR = 2'd1;
    localparam logic [1:0] STATUS_QUEUED    = 2'd2;

    typedef struct packed {
        logic [1:0] command;
        logic [4:0] task_id;
        logic       task_id_valid;
        logic       task_is_ready;
        logic [7:0] task_priority;
        logic [4:0] current_id;
        logic [7:0] current_priority;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic       next_valid;
        logic [4:0] next_id;
        logic       switch_now;
        logic       timer_stop;
        logic       timer_start;
        logic       is_ready;
    } out_item_t;

    // One queue slot: task id and its priority.
    typedef struct packed {
        logic [4:0] id;
        logic [7:0] prio;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_UP,
        S_PLACE,
        S_SHIFT_DOWN,
        S_RESULT
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/prq_mem.sv -----
// ----------------------------------------------------------------------------
// prq_mem
// Queue storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module prq_mem #(
    parameter int TASKS = 32
) (
    input  wire                        clk,
    input  wire                        rd_en,
    input  wire  [$clog2(TASKS)-1:0]   rd_addr,
    output prq_pkg::entry_t            rd_data,
    input  wire                        wr_en,
    input  wire  [$clog2(TASKS)-1:0]   wr_addr,
    input  prq_pkg::entry_t            wr_data
);

    prq_pkg::entry_t entry_mem [TASKS];
    prq_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/prq_ctrl.sv -----
// ----------------------------------------------------------------------------
// prq_ctrl
// Sequencer that scans, shifts and rewrites the sorted ready queue in memory.
// ----------------------------------------------------------------------------
`default_nettype none

module prq_ctrl #(
    parameter int TASKS           = 32,
    parameter int PRIORITY_LEVELS = 256
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        cmd_valid,
    output logic                       cmd_ready,
    input  prq_pkg::in_item_t          cmd,
    output logic                       res_load,
    input  wire                        res_free,
    output prq_pkg::out_item_t         res,
    output logic                       rd_en,
    output logic [$clog2(TASKS)-1:0]   rd_addr,
    input  prq_pkg::entry_t            rd_data,
    output logic                       wr_en,
    output logic [$clog2(TASKS)-1:0]   wr_addr,
    output prq_pkg::entry_t            wr_data
);

    localparam int AW = $clog2(TASKS);
    localparam int CW = $clog2(TASKS + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TASKS);
    localparam logic [CW-1:0] ONE        = CW'(1);
    localparam logic [8:0]    TASK_LIMIT = 9'(TASKS);
    localparam logic [16:0]   PRIO_LIMIT = 17'(PRIORITY_LEVELS);

    prq_pkg::state_t    state_reg, state_next;
    prq_pkg::in_item_t  cmd_reg, cmd_next;
    prq_pkg::out_item_t res_reg, res_next;
    prq_pkg::entry_t    head_reg, head_next;
    logic [7:0]         second_reg, second_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      issue_reg, issue_next;
    logic [CW-1:0]      tag_reg, tag_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic [CW-1:0]      at_reg, at_next;
    logic               pend_reg, pend_next;
    logic               found_reg, found_next;

    logic [CW-1:0]      rd_idx;
    logic [CW-1:0]      wr_idx;
    logic               id_in_range;
    logic               prio_in_range;
    logic               basic_ok;

    assign id_in_range   = ({4'b0, cmd_reg.task_id} < TASK_LIMIT);
    assign prio_in_range = ({9'b0, cmd_reg.task_priority} < PRIO_LIMIT);
    assign basic_ok      = cmd_reg.task_is_ready && cmd_reg.task_id_valid &&
                           id_in_range && prio_in_range;

    assign rd_addr = rd_idx[AW-1:0];
    assign wr_addr = wr_idx[AW-1:0];
    assign res     = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= prq_pkg::S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        res_reg    <= res_next;
        head_reg   <= head_next;
        second_reg <= second_next;
        issue_reg  <= issue_next;
        tag_reg    <= tag_next;
        pos_reg    <= pos_next;
        at_reg     <= at_next;
        found_reg  <= found_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        res_next    = res_reg;
        head_next   = head_reg;
        second_next = second_reg;
        count_next  = count_reg;
        issue_next  = issue_reg;
        tag_next    = tag_reg;
        pos_next    = pos_reg;
        at_next     = at_reg;
        found_next  = found_reg;
        pend_next   = 1'b0;
        cmd_ready   = 1'b0;
        res_load    = 1'b0;
        rd_en       = 1'b0;
        rd_idx      = issue_reg;
        wr_en       = 1'b0;
        wr_idx      = tag_reg;
        wr_data     = rd_data;

        case (state_reg)
            prq_pkg::S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    res_next   = '0;
                    issue_next = '0;
                    found_next = 1'b0;
                    pos_next   = '0;
                    at_next    = '0;
                    state_next = prq_pkg::S_SCAN;
                end
            end

            prq_pkg::S_SCAN:
            begin
                // Data returned this cycle belongs to the read issued last cycle.
                if (pend_reg)
                begin
                    if (rd_data.id == cmd_reg.task_id)
                    begin
                        found_next = 1'b1;
                        pos_next   = tag_reg;
                    end
                    if (rd_data.prio >= cmd_reg.task_priority)
                    begin
                        at_next = at_reg + ONE;
                    end
                    if (tag_reg == '0)
                    begin
                        head_next = rd_data;
                    end
                    if (tag_reg == ONE)
                    begin
                        second_next = rd_data.prio;
                    end
                end

                if (issue_reg < count_reg)
                begin
                    rd_en      = 1'b1;
                    rd_idx     = issue_reg;
                    pend_next  = 1'b1;
                    tag_next   = issue_reg;
                    issue_next = issue_reg + ONE;
                end
                else if (!pend_reg)
                begin
                    state_next = prq_pkg::S_RESULT;
                    case (cmd_reg.command)
                        prq_pkg::CMD_RESCHEDULE:
                        begin
                            if (basic_ok && found_reg)
                            begin
                                res_next.status = prq_pkg::STATUS_QUEUED;
                            end
                            else if (!basic_ok || (count_reg == FULL_COUNT))
                            begin
                                res_next.status = prq_pkg::STATUS_VALUE_ERR;
                            end
                            else
                            begin
                                if (cmd_reg.task_id != cmd_reg.current_id)
                                begin
                                    if (cmd_reg.task_priority > cmd_reg.current_priority)
                                    begin
                                        res_next.switch_now = 1'b1;
                                    end
                                    else if (cmd_reg.task_priority ==
                                             cmd_reg.current_priority)
                                    begin
                                        res_next.timer_start = 1'b1;
                                    end
                                end
                                issue_next = count_reg;
                                state_next = (at_reg == count_reg) ? prq_pkg::S_PLACE
                                                                   : prq_pkg::S_SHIFT_UP;
                            end
                        end

                        prq_pkg::CMD_UNSCHEDULE:
                        begin
                            if (found_reg)
                            begin
                                issue_next = pos_reg + ONE;
                                state_next = prq_pkg::S_SHIFT_DOWN;
                            end
                        end

                        prq_pkg::CMD_TAKE_NEXT:
                        begin
                            res_next.timer_stop = 1'b1;
                            if (count_reg != '0)
                            begin
                                res_next.next_valid  = 1'b1;
                                res_next.next_id     = head_reg.id;
                                res_next.timer_start = (count_reg > ONE) &&
                                                       (second_reg == head_reg.prio);
                                issue_next = ONE;
                                state_next = prq_pkg::S_SHIFT_DOWN;
                            end
                        end

                        // Query is the only remaining command.
                        default:
                        begin
                            res_next.is_ready = found_reg;
                        end
                    endcase
                end
            end

            prq_pkg::S_SHIFT_UP:
            begin
                // Move entries one slot toward the tail, last entry first.
                if (pend_reg)
                begin
                    wr_en  = 1'b1;
                    wr_idx = tag_reg + ONE;
                end
                if (issue_reg > at_reg)
                begin
                    rd_en      = 1'b1;
                    rd_idx     = issue_reg - ONE;
                    pend_next  = 1'b1;
                    tag_next   = issue_reg - ONE;
                    issue_next = issue_reg - ONE;
                end
                else if (!pend_reg)
                begin
                    state_next = prq_pkg::S_PLACE;
                end
            end

            prq_pkg::S_PLACE:
            begin
                wr_en        = 1'b1;
                wr_idx       = at_reg;
                wr_data.id   = cmd_reg.task_id;
                wr_data.prio = cmd_reg.task_priority;
                count_next   = count_reg + ONE;
                state_next   = prq_pkg::S_RESULT;
            end

            prq_pkg::S_SHIFT_DOWN:
            begin
                // Close the gap left by the removed entry, head side first.
                if (pend_reg)
                begin
                    wr_en  = 1'b1;
                    wr_idx = tag_reg - ONE;
                end
                if (issue_reg < count_reg)
                begin
                    rd_en      = 1'b1;
                    rd_idx     = issue_reg;
                    pend_next  = 1'b1;
                    tag_next   = issue_reg;
                    issue_next = issue_reg + ONE;
                end
                else if (!pend_reg)
                begin
                    count_next = count_reg - ONE;
                    state_next = prq_pkg::S_RESULT;
                end
            end

            prq_pkg::S_RESULT:
            begin
                if (res_free)
                begin
                    res_load   = 1'b1;
                    state_next = prq_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = prq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/priority_ready_queue_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler_top
// Ready queue of task ids sorted by priority, with switch and timer hints.
// ----------------------------------------------------------------------------
// Usage:
// Commands enter on cmd_valid/cmd_ready with payload cmd; each command gives
// exactly one response item on rsp_valid/rsp_ready with payload rsp.
// The queue lives in a single-port-read, single-port-write memory and every
// command first walks all queued entries, one read per cycle. A query or a
// rejected command needs only this walk before its response. An insert or a
// removal then shifts the entries behind the affected slot through the same
// memory port, one entry per cycle, before its response is given.
// The memory read port sets this rate.
// One command is worked on at a time; the next command can be accepted while
// a response still waits in the output register.
// When the receiver stalls, the response is held in the output register and
// a finished command waits for it before it can return to idle.
// Reset empties the queue; the storage itself is not cleared and needs no
// clearing pass, so commands are accepted right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_ready_queue_scheduler_top #(
    parameter int TASKS           = 32,
    parameter int PRIORITY_LEVELS = 256
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cmd_valid,
    output logic                 cmd_ready,
    input  prq_pkg::in_item_t    cmd,
    output logic                 rsp_valid,
    input  wire                  rsp_ready,
    output prq_pkg::out_item_t   rsp
);

    `include "priority_ready_queue_scheduler_top_macros.svh"

    localparam int AW = $clog2(TASKS);

    prq_pkg::out_item_t  res;
    prq_pkg::out_item_t  rsp_reg;
    prq_pkg::entry_t     rd_data;
    prq_pkg::entry_t     wr_data;
    logic                res_load;
    logic                res_free;
    logic                rsp_valid_reg, rsp_valid_next;
    logic                rd_en;
    logic                wr_en;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;

    prq_ctrl #(
        .TASKS           (TASKS),
        .PRIORITY_LEVELS (PRIORITY_LEVELS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_load  (res_load),
        .res_free  (res_free),
        .res       (res),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    prq_mem #(
        .TASKS (TASKS)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // The output register is free when empty or when its item leaves this cycle.
    assign res_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `PRQ_ASSERT_SAME(a_no_overwrite, res_load, (!rsp_valid_reg || rsp_ready), "response overwritten")
    `PRQ_ASSERT_NEXT(a_one_at_a_time, (cmd_valid && cmd_ready), !cmd_ready, "second command taken")
    `PRQ_ASSERT_SAME(a_hint_exclusive, rsp_valid_reg, !(rsp_reg.switch_now && rsp_reg.timer_start), "switch and timer start together")
    `PRQ_ASSERT_SAME(a_pop_stops_timer, (rsp_valid_reg && rsp_reg.next_valid), rsp_reg.timer_stop, "pop without timer stop")

endmodule

`default_nettype wire

// ----- verif/priority_ready_queue_scheduler_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler_top_tb
// Self-checking bench for the ready-queue scheduler. It keeps its own sorted
// ready queue, predicts every response from the commands it has sent, and
// compares each response field by field. Directed commands cover the corner
// cases first. Random traffic then fills and drains the queue while both
// handshakes idle at random.
// ----------------------------------------------------------------------------

module priority_ready_queue_scheduler_top_tb;

    localparam int TASK_COUNT   = 32;
    localparam int PRIO_LEVELS  = 256;
    localparam int RANDOM_ITEMS = 700;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 100;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIX
    } traffic_mode_t;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_EVERY_FOURTH,
        READY_SPARSE
    } ready_pattern_t;

    // Keeps the predicted ready queue and the responses still owed by the block.
    class sched_scoreboard;
        prq_pkg::entry_t    ready_q[$];
        prq_pkg::out_item_t expected_q[$];
        int                 errors;
        int                 cmd_hits[4];
        int                 full_inserts;
        int                 deepest;
        int                 switch_hints;
        int                 start_hints;

        function new();
            errors       = 0;
            full_inserts = 0;
            deepest      = 0;
            switch_hints = 0;
            start_hints  = 0;
            foreach (cmd_hits[i]) cmd_hits[i] = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function int position_of(logic [4:0] id);
            foreach (ready_q[i])
            begin
                if (ready_q[i].id == id) return i;
            end
            return -1;
        endfunction

        // Random id that is queued or absent as asked, or -1 if there is none.
        function int pick_id(bit want_queued);
            int ids[$];
            for (int i = 0; i < TASK_COUNT; i++)
            begin
                if ((position_of(5'(i)) >= 0) == want_queued) ids.push_back(i);
            end
            if (ids.size() == 0) return -1;
            return ids[$urandom_range(0, ids.size() - 1)];
        endfunction

        function void note_command(prq_pkg::in_item_t c);
            prq_pkg::out_item_t r;
            prq_pkg::entry_t    e;
            int                 pos;
            int                 at;
            bit                 args_ok;
            logic [7:0]         popped;
            r   = '0;
            pos = position_of(c.task_id);
            cmd_hits[c.command]++;
            case (c.command)
                prq_pkg::CMD_RESCHEDULE:
                begin
                    // The field widths match TASKS and PRIORITY_LEVELS exactly, so an
                    // id or priority out of range cannot be encoded.
                    args_ok = c.task_is_ready && c.task_id_valid;
                    if (!args_ok || ready_q.size() >= TASK_COUNT)
                    begin
                        if (args_ok) full_inserts++;
                        r.status = (args_ok && pos >= 0) ? prq_pkg::STATUS_QUEUED
                                                         : prq_pkg::STATUS_VALUE_ERR;
                    end
                    else if (pos >= 0)
                    begin
                        r.status = prq_pkg::STATUS_QUEUED;
                    end
                    else
                    begin
                        // New entry goes behind every entry of equal or higher priority.
                        at = 0;
                        while (at < ready_q.size() && ready_q[at].prio >= c.task_priority)
                            at++;
                        e.id   = c.task_id;
                        e.prio = c.task_priority;
                        ready_q.insert(at, e);
                        if (c.task_id != c.current_id)
                        begin
                            if (c.task_priority > c.current_priority)
                                r.switch_now = 1'b1;
                            else if (c.task_priority == c.current_priority)
                                r.timer_start = 1'b1;
                        end
                    end
                end
                prq_pkg::CMD_UNSCHEDULE:
                begin
                    if (pos >= 0) ready_q.delete(pos);
                end
                prq_pkg::CMD_TAKE_NEXT:
                begin
                    r.timer_stop = 1'b1;
                    if (ready_q.size() > 0)
                    begin
                        popped       = ready_q[0].prio;
                        r.next_valid = 1'b1;
                        r.next_id    = ready_q[0].id;
                        void'(ready_q.pop_front());
                        if (ready_q.size() > 0 && ready_q[0].prio == popped)
                            r.timer_start = 1'b1;
                    end
                end
                default:
                begin
                    r.is_ready = (pos >= 0);
                end
            endcase
            if (ready_q.size() > deepest) deepest = ready_q.size();
            if (r.switch_now) switch_hints++;
            if (r.timer_start) start_hints++;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [7:0] want_v, logic [7:0] got_v);
            if (got_v !== want_v)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(prq_pkg::out_item_t got);
            prq_pkg::out_item_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: response with no command outstanding, expected none, actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("status", 8'(want.status), 8'(got.status));
            compare_field("next_valid", 8'(want.next_valid), 8'(got.next_valid));
            compare_field("next_id", 8'(want.next_id), 8'(got.next_id));
            compare_field("switch_now", 8'(want.switch_now), 8'(got.switch_now));
            compare_field("timer_stop", 8'(want.timer_stop), 8'(got.timer_stop));
            compare_field("timer_start", 8'(want.timer_start), 8'(got.timer_start));
            compare_field("is_ready", 8'(want.is_ready), 8'(got.is_ready));
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               cmd_ready;
    prq_pkg::in_item_t  cmd       = '0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    prq_pkg::out_item_t rsp;

    int         burst_left    = 0;
    int         hold_requests = 0;
    int         cycles        = 0;
    logic [7:0] prio_pool [4] = '{8'd0, 8'd1, 8'd128, 8'd255};

    sched_scoreboard sb = new();

    priority_ready_queue_scheduler_top #(
        .TASKS           (TASK_COUNT),
        .PRIORITY_LEVELS (PRIO_LEVELS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #4 clk = ~clk;

    function automatic prq_pkg::in_item_t build_cmd(logic [1:0] op, logic [4:0] id, bit idv,
                                                    bit rdy, logic [7:0] prio,
                                                    logic [4:0] cur_id,
                                                    logic [7:0] cur_prio);
        prq_pkg::in_item_t c;
        c.command          = op;
        c.task_id          = id;
        c.task_id_valid    = idv;
        c.task_is_ready    = rdy;
        c.task_priority    = prio;
        c.current_id       = cur_id;
        c.current_priority = cur_prio;
        return c;
    endfunction

    // Offers one item and holds it until accepted; bursts end in a random gap.
    task automatic issue(input prq_pkg::in_item_t it);
        int gap;
        cmd       <= it;
        cmd_valid <= 1'b1;
        do @(posedge clk); while (!cmd_ready);
        sb.note_command(it);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            if (gap > 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    initial
    begin : rsp_side
        int             mode_left;
        int             hold_left;
        int             hold_served;
        int             phase;
        ready_pattern_t pattern;
        bit             take;
        mode_left   = 0;
        hold_left   = 0;
        hold_served = 0;
        phase       = 0;
        pattern     = READY_ALWAYS;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && rsp_ready) sb.check_result(rsp);
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left   = LONG_HOLD;
            end
            if (mode_left == 0)
            begin
                pattern   = ready_pattern_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 150);
            end
            else
            begin
                mode_left--;
            end
            phase++;
            case (pattern)
                READY_ALWAYS:       take = 1'b1;
                READY_COIN:         take = ($urandom_range(0, 1) == 1);
                READY_EVERY_FOURTH: take = (phase % 4 == 0);
                default:            take = ($urandom_range(0, 3) == 0);
            endcase
            // A long hold-off lets the output register and the engine back up.
            if (hold_left > 0)
            begin
                hold_left--;
                take = 1'b0;
            end
            rsp_ready <= take;
        end
    end

    initial
    begin : watchdog
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        prq_pkg::in_item_t it;
        traffic_mode_t     mode;
        int                roll;
        int                pick;
        int                res_cut;
        int                uns_cut;
        int                take_cut;
        mode = MODE_MIX;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty queue: take-next, query and unschedule of an absent task.
        issue(build_cmd(prq_pkg::CMD_TAKE_NEXT, 5'd0, 1'b1, 1'b1, 8'd0, 5'd0, 8'd0));
        issue(build_cmd(prq_pkg::CMD_QUERY, 5'd31, 1'b1, 1'b1, 8'd255, 5'd31, 8'd255));
        issue(build_cmd(prq_pkg::CMD_UNSCHEDULE, 5'd31, 1'b1, 1'b1, 8'd255, 5'd31, 8'd255));
        // Rejected reschedules: task not ready, then invalid id.
        issue(build_cmd(prq_pkg::CMD_RESCHEDULE, 5'd5, 1'b1, 1'b0, 8'd9, 5'd0, 8'd0));
        issue(build_cmd(prq_pkg::CMD_RESCHEDULE, 5'd5, 1'b0, 1'b1, 8'd9, 5'd0, 8'd0));
        // Equal priority starts the timer, higher priority asks for a switch.
        issue(build_cmd(prq_pkg::CMD_RESCHEDULE, 5'd0, 1'b1, 1'b1, 8'd0, 5'd1, 8'd0));
        issue(build_cmd(prq_pkg::CMD_RESCHEDULE, 5'd31, 1'b1, 1'b1, 8'd255, 5'd0, 8'd254));
        // Already queued, with good and with bad arguments.
        issue(build_cmd(prq_pkg::CMD_RESCHEDULE, 5'd31, 1'b1, 1'b1, 8'd255, 5'd0, 8'd254));
        issue(build_cmd(prq_pkg::CMD_RESCHEDULE, 5'd31, 1'b0, 1'b0, 8'd255, 5'd0, 8'd0));
        // The running task itself, a lower one, and an equal one behind it.
        issue(build_cmd(prq_pkg::CMD_RESCHEDULE, 5'd10, 1'b1, 1'b1, 8'd100, 5'd10, 8'd50));
        issue(build_cmd(prq_pkg::CMD_RESCHEDULE, 5'd11, 1'b1, 1'b1, 8'd100, 5'd3, 8'd200));
        issue(build_cmd(prq_pkg::CMD_RESCHEDULE, 5'd12, 1'b1, 1'b1, 8'd100, 5'd3, 8'd100));
        issue(build_cmd(prq_pkg::CMD_QUERY, 5'd11, 1'b1, 1'b1, 8'd0, 5'd0, 8'd0));
        issue(build_cmd(prq_pkg::CMD_UNSCHEDULE, 5'd11, 1'b1, 1'b1, 8'd0, 5'd0, 8'd0));
        issue(build_cmd(prq_pkg::CMD_QUERY, 5'd11, 1'b1, 1'b1, 8'd0, 5'd0, 8'd0));
        // Drain in order; the second pop leaves an equal-priority head.
        repeat (5)
            issue(build_cmd(prq_pkg::CMD_TAKE_NEXT, 5'd31, 1'b0, 1'b0, 8'd255, 5'd31,
                            8'd255));

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0) mode = traffic_mode_t'($urandom_range(0, 2));
            if (n == 150 || n == 500) hold_requests++;
            if (n == 320)
            begin
                cmd_valid <= 1'b0;
                do @(posedge clk); while (sb.pending() != 0);
            end
            case (mode)
                MODE_FILL:
                begin
                    res_cut = 75; uns_cut = 83; take_cut = 90;
                end
                MODE_DRAIN:
                begin
                    res_cut = 20; uns_cut = 40; take_cut = 80;
                end
                default:
                begin
                    res_cut = 45; uns_cut = 60; take_cut = 80;
                end
            endcase
            roll = $urandom_range(0, 99);
            it.command = (roll < res_cut) ? prq_pkg::CMD_RESCHEDULE :
                         (roll < uns_cut) ? prq_pkg::CMD_UNSCHEDULE :
                         (roll < take_cut) ? prq_pkg::CMD_TAKE_NEXT : prq_pkg::CMD_QUERY;
            it.task_id = 5'($urandom_range(0, 31));
            pick = -1;
            if (it.command == prq_pkg::CMD_RESCHEDULE && $urandom_range(0, 9) < 6)
                pick = sb.pick_id(1'b0);
            else if (it.command != prq_pkg::CMD_RESCHEDULE && $urandom_range(0, 1) == 1)
                pick = sb.pick_id(1'b1);
            if (pick >= 0) it.task_id = 5'(pick);
            it.task_id_valid    = ($urandom_range(0, 9) != 0);
            it.task_is_ready    = ($urandom_range(0, 9) != 0);
            it.task_priority    = ($urandom_range(0, 1) == 0) ? prio_pool[$urandom_range(0, 3)]
                                                             : 8'($urandom_range(0, 255));
            it.current_id       = ($urandom_range(0, 6) == 0) ? it.task_id
                                                             : 5'($urandom_range(0, 31));
            it.current_priority = ($urandom_range(0, 2) == 0) ? it.task_priority
                                                             : 8'($urandom_range(0, 255));
            issue(it);
        end

        cmd_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d commands: %0d reschedule, %0d unschedule, %0d take-next, %0d query.",
                 sb.cmd_hits[0] + sb.cmd_hits[1] + sb.cmd_hits[2] + sb.cmd_hits[3],
                 sb.cmd_hits[prq_pkg::CMD_RESCHEDULE], sb.cmd_hits[prq_pkg::CMD_UNSCHEDULE],
                 sb.cmd_hits[prq_pkg::CMD_TAKE_NEXT], sb.cmd_hits[prq_pkg::CMD_QUERY]);
        $display("Queue peaked at %0d of %0d; %0d inserts hit a full queue; %0d switch, %0d %s",
                 sb.deepest, TASK_COUNT, sb.full_inserts, sb.switch_hints, sb.start_hints,
                 "timer hints.");
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
